// ----- src/igli_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package igli_pkg;
    localparam int CMD_W   = 3;
    localparam int PIDX_W  = 6;
    localparam int SIDX_W  = 3;
    localparam int VAL_W   = 32;
    localparam int RAD_W   = 16;
    localparam int FRAC_W  = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_GRID = 3'd0,
        CMD_LOAD_TEMP = 3'd1,
        CMD_LOAD_DENS = 3'd2,
        CMD_EVAL_ONE  = 3'd3,
        CMD_EVAL_ALL  = 3'd4
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POINTS  = 1'd0,
        REG_SPECIES = 1'd1
    } reg_idx_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [PIDX_W-1:0] point_index;
        logic [SIDX_W-1:0] species_index;
        logic [VAL_W-1:0]  load_value;
        logic [RAD_W-1:0]  query_radius;
    } in_item_t;

    typedef struct packed {
        logic [SIDX_W-1:0] out_species;
        logic [VAL_W-1:0]  density;
        logic [VAL_W-1:0]  temperature;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic              start;
        logic [RAD_W-1:0]  num;
        logic [RAD_W-1:0]  den;
    } div_req_t;
endpackage
`default_nettype wire

// ----- src/igli_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface igli_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- src/igli_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider: (num << 16) / den, one quotient bit per cycle.
module igli_div
    import igli_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire div_req_t         req,
    output logic                  done,
    output logic [FRAC_W-1:0]     quot
);
    localparam int CNT_W = $clog2(FRAC_W + 1);
    logic [RAD_W:0]        rem_reg, rem_next;
    logic [RAD_W-1:0]      den_reg, den_next;
    logic [FRAC_W-1:0]     q_reg, q_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic [RAD_W+1:0]      trial;

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, 1'b0} - {2'b00, den_reg};
        if (req.start)
        begin
            rem_next  = {1'b0, req.num};
            den_next  = req.den;
            q_next    = '0;
            cnt_next  = CNT_W'(FRAC_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[RAD_W+1])
            begin
                rem_next = trial[RAD_W:0];
                q_next   = {q_reg[FRAC_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[RAD_W-1:0], 1'b0};
                q_next   = {q_reg[FRAC_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign done = busy_reg && (cnt_reg == CNT_W'(1));
    assign quot = q_next;
endmodule
`default_nettype wire

// ----- src/irregular_grid_linear_interpolator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Piecewise linear interpolator over an irregular radial grid. Load items
// write one grid radius or one table entry. An evaluate item searches the
// grid linearly, one memory read per cycle, after the set-up states G0, GN
// and CHK. When the radius falls inside the grid a serial divider then
// forms the fraction. Each reported species passes two reads of the density
// and temperature memories, a two-stage multiply and the output hand-off; a
// result that has not been taken holds the next one back. Out of range
// clamps: radius below the first point uses entry 0, at or above the last
// uses entry n-1. In evaluate-all, species 2 and up report species 1's
// temperature. The stores are not cleared; read only written entries.
module irregular_grid_linear_interpolator
    import igli_pkg::*;
#(
    parameter int MAX_POINTS  = 64,
    parameter int MAX_SPECIES = 8
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    igli_if.sink                       in_ch,
    igli_if.source                     out_ch,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);
    localparam int PW  = $clog2(MAX_POINTS);
    localparam int SW  = (MAX_SPECIES > 1) ? $clog2(MAX_SPECIES) : 1;
    localparam int AW  = PW + SW;
    localparam int NW  = $clog2(MAX_POINTS + 1);
    localparam int NSW = $clog2(MAX_SPECIES + 1);

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_G0    = 11'b00000000010,
        ST_GN    = 11'b00000000100,
        ST_CHK   = 11'b00000001000,
        ST_SRCH  = 11'b00000010000,
        ST_DIV   = 11'b00000100000,
        ST_RD1   = 11'b00001000000,
        ST_RD2   = 11'b00010000000,
        ST_MUL   = 11'b00100000000,
        ST_SUM   = 11'b01000000000,
        ST_OUT   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] grid_mem [MAX_POINTS];
    logic [31:0] temp_mem [MAX_SPECIES*MAX_POINTS];
    logic [31:0] dens_mem [MAX_SPECIES*MAX_POINTS];
    logic [15:0] grid_q;
    logic [31:0] temp_q, dens_q;

    logic [6:0] pts_reg;
    logic [3:0] spc_reg;
    logic [NW-1:0]  n_eff;
    logic [NSW-1:0] ns_eff;

    in_item_t  item_reg;
    logic      all_reg;
    logic [1:0] mode_reg;
    logic [PW-1:0] seg_reg;
    logic [PW-1:0] idx_reg;
    logic [15:0] lo_reg, g0_reg;
    logic [SW-1:0] sp_reg;
    logic [FRAC_W-1:0] frac_reg;
    logic [31:0] d1_reg, t1_reg;
    logic [47:0] da_reg, db_reg, ta_reg, tb_reg;
    logic [31:0] ion_reg;
    out_item_t out_reg;
    logic      out_valid_reg;

    logic      grid_we, temp_we, dens_we;
    logic [PW-1:0] grid_ra;
    logic [AW-1:0] tab_ra, tab_wa;
    logic      pt_ok, sp_ok;
    div_req_t  dreq;
    logic      div_done;
    logic [FRAC_W-1:0] div_q;
    logic      go_load;
    logic [PW-1:0] pt_of_read;
    logic [16:0] tinv;
    logic [31:0] d_res, t_res;
    logic      is_last;

    always_comb
    begin
        n_eff = (pts_reg == 7'd0) ? NW'(1)
              : ({25'd0, pts_reg} > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(pts_reg);
        ns_eff = (spc_reg == 4'd0) ? NSW'(1)
               : ({28'd0, spc_reg} > MAX_SPECIES) ? NSW'(MAX_SPECIES) : NSW'(spc_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pts_reg <= 7'd1;
            spc_reg <= 4'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_POINTS:  pts_reg <= cfg_data;
                REG_SPECIES: spc_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign go_load = in_ch.valid && in_ch.ready;

    assign pt_ok = ({26'd0, in_ch.data.point_index} < MAX_POINTS);
    assign sp_ok = ({29'd0, in_ch.data.species_index} < MAX_SPECIES);
    assign grid_we = go_load && pt_ok && (in_ch.data.command == CMD_LOAD_GRID);
    assign temp_we = go_load && pt_ok && sp_ok && (in_ch.data.command == CMD_LOAD_TEMP);
    assign dens_we = go_load && pt_ok && sp_ok && (in_ch.data.command == CMD_LOAD_DENS);
    assign tab_wa = {SW'(in_ch.data.species_index), PW'(in_ch.data.point_index)};

    // grid read address: entry 0, entry n-1, or the entry the search needs next
    always_comb
    begin
        case (state_reg)
            ST_IDLE: grid_ra = '0;
            ST_G0:   grid_ra = PW'(n_eff - 1'b1);
            ST_SRCH: grid_ra = (grid_q <= item_reg.query_radius) ? idx_reg + 1'b1 : idx_reg;
            default: grid_ra = idx_reg;
        endcase
    end

    // table point: clamp entries or segment ends
    always_comb
    begin
        case (mode_reg)
            2'd0:    pt_of_read = '0;
            2'd1:    pt_of_read = PW'(n_eff - 1'b1);
            default: pt_of_read = (state_reg == ST_RD2) ? seg_reg + 1'b1 : seg_reg;
        endcase
    end
    assign tab_ra = {sp_reg, pt_of_read};

    always_ff @(posedge clk)
    begin
        if (grid_we)
            grid_mem[PW'(in_ch.data.point_index)] <= in_ch.data.load_value[15:0];
        grid_q <= grid_mem[grid_ra];
        if (temp_we)
            temp_mem[tab_wa] <= in_ch.data.load_value;
        temp_q <= temp_mem[tab_ra];
        if (dens_we)
            dens_mem[tab_wa] <= in_ch.data.load_value;
        dens_q <= dens_mem[tab_ra];
    end

    igli_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .done  (div_done),
        .quot  (div_q)
    );

    assign tinv = 17'h10000 - {1'b0, frac_reg};
    assign d_res = 32'((da_reg + db_reg) >> 16);
    assign t_res = 32'((ta_reg + tb_reg) >> 16);
    assign is_last = !all_reg || ({{(NSW-SW){1'b0}}, sp_reg} == ns_eff - 1'b1);

    always_comb
    begin
        state_next = state_reg;
        dreq = '0;
        case (state_reg)
            ST_IDLE:
                if (go_load && (in_ch.data.command == CMD_EVAL_ALL ||
                    (in_ch.data.command == CMD_EVAL_ONE &&
                     {1'b0, in_ch.data.species_index} < 4'(ns_eff))))
                    state_next = ST_G0;
            ST_G0: state_next = ST_GN;
            ST_GN: state_next = ST_CHK;
            ST_CHK:
                if (mode_reg != 2'd2)
                    state_next = ST_RD1;
                else
                    state_next = ST_SRCH;
            ST_SRCH:
                if (grid_q > item_reg.query_radius)
                begin
                    dreq.start = 1'b1;
                    dreq.num = item_reg.query_radius - lo_reg;
                    dreq.den = grid_q - lo_reg;
                    state_next = ST_DIV;
                end
            ST_DIV: if (div_done) state_next = ST_RD1;
            ST_RD1: state_next = ST_RD2;
            ST_RD2: state_next = ST_MUL;
            ST_MUL: state_next = ST_SUM;
            // hold until the previous result has been taken
            ST_SUM: if (!out_valid_reg) state_next = ST_OUT;
            ST_OUT:
                if (!out_valid_reg)
                    state_next = is_last ? ST_IDLE : ST_RD1;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ch.ready)
                out_valid_reg <= 1'b0;
            else if (state_reg == ST_OUT && !out_valid_reg)
                out_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                item_reg <= in_ch.data;
                all_reg  <= (in_ch.data.command == CMD_EVAL_ALL);
                sp_reg   <= (in_ch.data.command == CMD_EVAL_ALL) ? '0
                            : SW'(in_ch.data.species_index);
                idx_reg  <= '0;
            end
            ST_G0:
            begin
                // grid_q holds entry 0
                g0_reg  <= grid_q;
                idx_reg <= PW'(1);
            end
            ST_GN:
            begin
                // grid_q holds entry n-1; entry 1 read is issued now
                mode_reg <= (item_reg.query_radius < g0_reg) ? 2'd0
                          : (item_reg.query_radius >= grid_q) ? 2'd1 : 2'd2;
                lo_reg   <= g0_reg;
                seg_reg  <= '0;
                idx_reg  <= PW'(1);
            end
            ST_SRCH:
            begin
                // grid_q is entry idx_reg; advance while it stays <= radius
                if (grid_q <= item_reg.query_radius)
                begin
                    lo_reg  <= grid_q;
                    seg_reg <= idx_reg;
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            ST_DIV: if (div_done) frac_reg <= div_q;
            ST_RD2:
            begin
                d1_reg <= dens_q;
                t1_reg <= temp_q;
            end
            ST_MUL:
            begin
                if (mode_reg == 2'd2)
                begin
                    da_reg <= 48'(d1_reg * tinv);
                    db_reg <= 48'(dens_q * {16'd0, frac_reg});
                    ta_reg <= 48'(t1_reg * tinv);
                    tb_reg <= 48'(temp_q * {16'd0, frac_reg});
                end
                else
                begin
                    da_reg <= {d1_reg, 16'd0};
                    db_reg <= '0;
                    ta_reg <= {t1_reg, 16'd0};
                    tb_reg <= '0;
                end
            end
            ST_SUM:
            begin
                if (!out_valid_reg)
                begin
                    out_reg.out_species <= SIDX_W'(sp_reg);
                    out_reg.density     <= d_res;
                    out_reg.temperature <= (all_reg && sp_reg >= SW'(2)) ? ion_reg : t_res;
                    out_reg.last        <= is_last;
                    if (sp_reg == SW'(1))
                        ion_reg <= t_res;
                end
            end
            ST_OUT: if (!out_valid_reg) sp_reg <= sp_reg + 1'b1;
            default: ;
        endcase
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;

    property p_ready_idle;
        @(posedge clk) disable iff (!rst_n) in_ch.ready |-> !out_valid_reg || out_reg.last;
    endproperty
    a_ready_idle: assert property (p_ready_idle) else $error("accepting during a run");

    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
            out_valid_reg && !out_ch.ready |=> out_valid_reg && $stable(out_reg);
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("result dropped");

    property p_div_bounded;
        @(posedge clk) disable iff (!rst_n)
            state_reg == ST_SRCH |-> {1'b0, idx_reg} < n_eff;
    endproperty
    a_div_bounded: assert property (p_div_bounded) else $error("search overran grid");
endmodule
`default_nettype wire
